// ===== hw/rtl/ratt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratt_pkg
// Shared codes, defaults and types for the region address translation table.
// ----------------------------------------------------------------------------
package ratt_pkg;

  // default table depth
  localparam int DEF_ENTRIES = 16;

  // request command codes
  localparam logic [1:0] CMD_MAP       = 2'd0;
  localparam logic [1:0] CMD_UNMAP     = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // largest region length, anything above is clipped to this
  localparam logic [32:0] LEN_MAX = 33'h1_0000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, clear search state
    logic rd_en;   // read the entry at the scan index
    logic commit;  // apply table update and form the result
  } ctl_t;

endpackage

// ===== hw/rtl/ratt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratt_ctrl
// Sequencer: accepts a request, walks every slot, then commits the result.
// ----------------------------------------------------------------------------
module ratt_ctrl #(
  parameter int ENTRIES = 16,
  parameter int IDXW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output ratt_pkg::ctl_t    ctl,
  output logic [IDXW-1:0]   rd_idx
);
  import ratt_pkg::*;

  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] cnt_next;

  assign busy   = (state != S_IDLE);
  assign rd_idx = cnt[IDXW-1:0];

  // next state and scan counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // the final scan state issues no read, so the last registered read can be evaluated
        if (cnt == CNT_LAST) begin
          state_next = S_DONE;
        end else begin
          ctl.rd_en = 1'b1;
          cnt_next  = cnt + 1'b1;
        end
      end
      S_DONE: begin
        ctl.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= (state == S_DONE);
    end
  end

endmodule

// ===== hw/rtl/ratt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratt_dp
// Region storage, per-slot match evaluation and result registers.
// ----------------------------------------------------------------------------
module ratt_dp #(
  parameter int ENTRIES = 16,
  parameter int IDXW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ratt_pkg::ctl_t    ctl,
  input  logic [IDXW-1:0]   rd_idx,
  input  logic [1:0]        command,
  input  logic [31:0]       virt_addr,
  input  logic [31:0]       phys_addr,
  input  logic [32:0]       region_size,
  output logic [1:0]        status,
  output logic [31:0]       phys_out
);
  import ratt_pkg::*;

  // region storage
  logic [31:0] mem_virt [ENTRIES];
  logic [31:0] mem_phys [ENTRIES];
  logic [32:0] mem_len  [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;

  // captured request
  logic [1:0]  req_cmd;
  logic [31:0] req_va;
  logic [31:0] req_pa;
  logic [32:0] req_len;

  // registered read of one slot
  logic            ev_en;
  logic [IDXW-1:0] ev_idx;
  logic            ev_vld;
  logic [31:0]     ev_virt;
  logic [31:0]     ev_phys;
  logic [32:0]     ev_len;

  // search state
  logic            dup;
  logic            have_free;
  logic [IDXW-1:0] free_idx;
  logic            found;
  logic [IDXW-1:0] hit_idx;
  logic [31:0]     best_base;
  logic [31:0]     best_phys;

  // slot evaluation
  logic        base_eq;
  logic [32:0] ev_end;
  logic        in_range;
  logic        wr_en;

  assign base_eq  = ev_vld && (ev_virt == req_va);
  assign ev_end   = {1'b0, ev_virt} + ev_len;
  assign in_range = ev_vld && (req_va >= ev_virt) && ({1'b0, req_va} < ev_end);
  assign wr_en    = ctl.commit && (req_cmd == CMD_MAP) && !dup && have_free;

  // request capture, length clipped to the full address space
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd <= command;
      req_va  <= virt_addr;
      req_pa  <= phys_addr;
      if (region_size > LEN_MAX) begin
        req_len <= LEN_MAX;
      end else begin
        req_len <= region_size;
      end
    end
  end

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_virt[free_idx] <= req_va;
      mem_phys[free_idx] <= req_pa;
      mem_len[free_idx]  <= req_len;
    end
    if (ctl.rd_en) begin
      ev_virt <= mem_virt[rd_idx];
      ev_phys <= mem_phys[rd_idx];
      ev_len  <= mem_len[rd_idx];
    end
  end

  // valid bits and read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      ev_en       <= 1'b0;
      ev_vld      <= 1'b0;
      ev_idx      <= '0;
    end else begin
      ev_en  <= ctl.rd_en;
      ev_idx <= rd_idx;
      ev_vld <= ctl.rd_en && entry_valid[rd_idx];
      if (wr_en) begin
        entry_valid[free_idx] <= 1'b1;
      end else if (ctl.commit && (req_cmd == CMD_UNMAP) && found) begin
        entry_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // per-slot search update
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dup       <= 1'b0;
      have_free <= 1'b0;
      found     <= 1'b0;
      free_idx  <= '0;
      hit_idx   <= '0;
      best_base <= '0;
      best_phys <= '0;
    end else if (ev_en) begin
      unique case (req_cmd)
        CMD_MAP: begin
          if (base_eq) begin
            dup <= 1'b1;
          end
          if (!ev_vld && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= ev_idx;
          end
        end
        CMD_UNMAP: begin
          if (base_eq && !found) begin
            found   <= 1'b1;
            hit_idx <= ev_idx;
          end
        end
        CMD_TRANSLATE: begin
          // lowest containing base wins
          if (in_range && (!found || (ev_virt < best_base))) begin
            found     <= 1'b1;
            best_base <= ev_virt;
            best_phys <= ev_phys;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      phys_out <= '0;
      unique case (req_cmd)
        CMD_MAP: begin
          if (dup) begin
            status <= ST_DUP;
          end else if (!have_free) begin
            status <= ST_FULL;
          end else begin
            status <= ST_OK;
          end
        end
        CMD_UNMAP: begin
          status <= found ? ST_OK : ST_MISS;
        end
        CMD_TRANSLATE: begin
          if (found) begin
            status   <= ST_OK;
            phys_out <= best_phys + (req_va - best_base);
          end else begin
            status <= ST_MISS;
          end
        end
        default: begin
          status <= ST_MISS;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/region_address_translation_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_address_translation_table
// Region table with map, unmap and translate requests over ENTRIES slots.
// ----------------------------------------------------------------------------
//  channel   signals                                        handshake
//  request   command virt_addr phys_addr region_size        start, busy
//  result    status phys_out                                done strobe
//
//  A request runs from accept to the done strobe in this order: the sequencer
//  reads one slot per cycle from the region storage (one read port), a final
//  scan state drains the registered read and the done state commits the result.
//  A new request may be taken in the cycle the done strobe is high, but none
//  while busy, so the table works on one request at a time.
//  Synchronous reset clears all valid bits at once; no clearing pass.
//  The done strobe marks the result for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module region_address_translation_table #(
  parameter int ENTRIES = ratt_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [32:0] region_size,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] phys_out
);
  import ratt_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ctl_t            ctl;
  logic [IDXW-1:0] rd_idx;

  // sequencer
  ratt_ctrl #(
    .ENTRIES (ENTRIES),
    .IDXW    (IDXW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .ctl    (ctl),
    .rd_idx (rd_idx)
  );

  // storage and search
  ratt_dp #(
    .ENTRIES (ENTRIES),
    .IDXW    (IDXW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .rd_idx      (rd_idx),
    .command     (command),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .region_size (region_size),
    .status      (status),
    .phys_out    (phys_out)
  );

endmodule

// ===== verif/tb_region_address_translation_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_address_translation_table
// Drives map, unmap and translate requests into the region table and checks
// every done strobe against a shadow copy of the table kept in the bench.
// Directed requests cover the corner cases, then random requests over a small
// pool of bases keep the table filling, overflowing and draining.
// ----------------------------------------------------------------------------
module tb_region_address_translation_table;
  import ratt_pkg::*;

  localparam int TABLE_DEPTH = DEF_ENTRIES;
  // command value with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1550;
  localparam int CALM_TAIL = 200;
  localparam int BASE_POOL = 24;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] phys;
  } table_reply_t;

  // shadow of the region table, predicts the reply of each accepted request
  class region_map_shadow;
    bit           slot_used [DEF_ENTRIES];
    logic [31:0]  slot_virt [DEF_ENTRIES];
    logic [31:0]  slot_phys [DEF_ENTRIES];
    logic [32:0]  slot_len  [DEF_ENTRIES];
    table_reply_t replies_owed[$];
    int           fail_total;

    function new();
      fail_total = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function table_reply_t resolve_request(logic [1:0] cmd, logic [31:0] va,
                                           logic [31:0] pa, logic [32:0] size);
      table_reply_t r;
      int           free_slot;
      int           hit;
      logic [32:0]  stop;
      r.status  = ST_MISS;
      r.phys    = '0;
      free_slot = -1;
      hit       = -1;
      case (cmd)
        CMD_MAP: begin
          // duplicate base wins over a full table
          r.status = ST_OK;
          for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (slot_used[i]) begin
              if (slot_virt[i] == va) r.status = ST_DUP;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (r.status == ST_OK && free_slot < 0) r.status = ST_FULL;
          if (r.status == ST_OK) begin
            slot_used[free_slot] = 1'b1;
            slot_virt[free_slot] = va;
            slot_phys[free_slot] = pa;
            slot_len[free_slot]  = (size > LEN_MAX) ? LEN_MAX : size;
          end
        end
        CMD_UNMAP: begin
          for (int i = 0; i < DEF_ENTRIES; i++)
            if (hit < 0 && slot_used[i] && slot_virt[i] == va) hit = i;
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            r.status = ST_OK;
          end
        end
        CMD_TRANSLATE: begin
          // lowest containing base wins, end computed 33 bits wide
          for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (slot_used[i]) begin
              stop = {1'b0, slot_virt[i]} + slot_len[i];
              if (va >= slot_virt[i] && {1'b0, va} < stop &&
                  (hit < 0 || slot_virt[i] < slot_virt[hit]))
                hit = i;
            end
          end
          if (hit >= 0) begin
            r.status = ST_OK;
            r.phys   = slot_phys[hit] + (va - slot_virt[hit]);
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void take_request(logic [1:0] cmd, logic [31:0] va,
                               logic [31:0] pa, logic [32:0] size);
      replies_owed.push_back(resolve_request(cmd, va, pa, size));
    endfunction

    function void match_reply(logic [1:0] status, logic [31:0] phys);
      table_reply_t want;
      if (replies_owed.size() == 0) begin
        fail_total++;
        if (fail_total <= 10)
          $display("%0t: reply with no request pending: status %0d phys %h",
                   $realtime, status, phys);
        return;
      end
      want = replies_owed.pop_front();
      if (want.status !== status || want.phys !== phys) begin
        fail_total++;
        if (fail_total <= 10)
          $display("%0t: mismatch: status exp %0d got %0d, phys exp %h got %h",
                   $realtime, want.status, status, want.phys, phys);
      end
    endfunction

    function int outstanding();
      return replies_owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_MAP;
  logic [31:0] virt_addr = '0;
  logic [31:0] phys_addr = '0;
  logic [32:0] region_size = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] phys_out;

  region_map_shadow shadow;
  logic [31:0]      base_pool [BASE_POOL];

  region_address_translation_table #(
    .ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .virt_addr(virt_addr),
    .phys_addr(phys_addr),
    .region_size(region_size),
    .done(done),
    .status(status),
    .phys_out(phys_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side, sampled before the edge updates land
  always @(posedge clk) begin
    if (!rst && done) shadow.match_reply(status, phys_out);
  end

  // present one request and hold it until the table takes it
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] va,
                              input logic [31:0] pa, input logic [32:0] size);
    start       <= 1'b1;
    command     <= cmd;
    virt_addr   <= va;
    phys_addr   <= pa;
    region_size <= size;
    do @(posedge clk); while (busy);
    shadow.take_request(cmd, va, pa, size);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every reply is back or the guard limit runs out
  task automatic drain_replies(input int limit);
    int guard;
    start <= 1'b0;
    guard = 0;
    while (shadow.outstanding() > 0 && guard < limit) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // stimulus
  initial begin
    logic [1:0]  cmd;
    logic [31:0] va;
    logic [31:0] pa;
    logic [32:0] size;
    logic [31:0] base;
    int          pick;
    int          map_share;
    bit          calm;

    shadow = new();
    base_pool[0] = 32'h0000_0000;
    base_pool[1] = 32'hFFFF_FFFF;
    base_pool[2] = 32'hFFFF_F000;
    // clustered bases so small regions overlap
    for (int k = 3; k < 10; k++) base_pool[k] = 32'h4000_0000 + k * 32'h900;
    for (int k = 10; k < BASE_POOL; k++) base_pool[k] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused command
    send_request(CMD_TRANSLATE, 32'h0000_0000, 32'h0, 33'h0);
    send_request(CMD_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    // physical side wraps at 32 bits, end is exclusive
    send_request(CMD_MAP, 32'h0000_1000, 32'hFFFF_F000, 33'h2000);
    send_request(CMD_TRANSLATE, 32'h0000_1FFF, 32'h0, 33'h0);
    send_request(CMD_TRANSLATE, 32'h0000_2FFF, 32'h0, 33'h0);
    send_request(CMD_TRANSLATE, 32'h0000_3000, 32'h0, 33'h0);
    send_request(CMD_MAP, 32'h0000_1000, 32'h1111_0000, 33'h10);
    // oversized length clipped, region reaches the top address
    send_request(CMD_MAP, 32'h8000_0000, 32'h0000_0000, 33'h1_FFFF_FFFF);
    send_request(CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 33'h0);
    // zero length holds its base but covers nothing
    send_request(CMD_MAP, 32'h0000_5000, 32'hABCD_0000, 33'h0);
    send_request(CMD_TRANSLATE, 32'h0000_5000, 32'h0, 33'h0);
    send_request(CMD_MAP, 32'h0000_5000, 32'h0, 33'h100);
    // overlapping regions, lowest base wins
    send_request(CMD_MAP, 32'h0000_0000, 32'h1234_0000, 33'h1_0000_0000);
    send_request(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1);
    send_request(CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 33'h0);
    send_request(CMD_TRANSLATE, 32'h0000_1800, 32'h0, 33'h0);
    send_request(CMD_UNMAP, 32'h0000_0000, 32'h0, 33'h0);
    send_request(CMD_UNMAP, 32'h0000_0000, 32'h0, 33'h0);
    send_request(CMD_TRANSLATE, 32'h0000_1800, 32'h0, 33'h0);

    // random requests over the base pool, alternating fill and drain spells
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= RANDOM_REQUESTS - CALM_TAIL);
      if (!calm && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 13));
      if (n % 300 == 150) drain_replies(100 * (TABLE_DEPTH + 3));
      map_share = (((n / 80) % 2) == 0) ? 50 : 25;
      pick = $urandom_range(0, 99);
      base = base_pool[$urandom_range(0, BASE_POOL - 1)];
      va   = base;
      pa   = $urandom;
      size = {1'($urandom_range(0, 1)), 32'($urandom)};
      if (pick < 5) begin
        cmd = CMD_UNUSED;
        va  = $urandom;
      end else if (pick < map_share) begin
        cmd = CMD_MAP;
        case ($urandom_range(0, 7))
          0: ;
          1: size = '0;
          default: size = 33'($urandom_range(1, 32'h4000));
        endcase
        if ($urandom_range(0, 7) == 0) va = $urandom;
      end else if (pick < map_share + 15) begin
        cmd = CMD_UNMAP;
        if ($urandom_range(0, 7) == 0) va = $urandom;
      end else begin
        cmd = CMD_TRANSLATE;
        case ($urandom_range(0, 9))
          0: va = $urandom;
          1: va = base - 32'd1;
          default: va = base + 32'($urandom_range(0, 32'h4800));
        endcase
      end
      send_request(cmd, va, pa, size);
    end

    // wind down
    drain_replies(100 * (TABLE_DEPTH + 3));
    repeat (TABLE_DEPTH + 5) @(posedge clk);
    if (shadow.fail_total == 0 && shadow.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
